// File: rtl/cau_pkg.sv
package cau_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;

  localparam logic [1:0] OP_ADD = 2'd0;
  localparam logic [1:0] OP_SUB = 2'd1;
  localparam logic [1:0] OP_MUL = 2'd2;
  localparam logic [1:0] OP_DIV = 2'd3;

  localparam int QBITS = 32;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] a_re;
    logic signed [31:0] a_im;
    logic signed [31:0] b_re;
    logic signed [31:0] b_im;
  } cau_in_t;

  typedef struct packed {
    logic signed [31:0] result_re;
    logic signed [31:0] result_im;
    logic               saturated;
    logic               divide_by_zero;
  } cau_out_t;

  // Divider pipeline word. For add, subtract and multiply the result travels in
  // val_re and val_im; for divide the remainder and quotient fields do the work.
  typedef struct packed {
    logic               valid;
    logic [1:0]         op;
    logic               dz;
    logic               ovf_re;
    logic               ovf_im;
    logic               neg_re;
    logic               neg_im;
    logic signed [65:0] val_re;
    logic signed [65:0] val_im;
    logic [63:0]        den;
    logic [63:0]        rem_re;
    logic [63:0]        rem_im;
    logic [QBITS-1:0]   nlo_re;
    logic [QBITS-1:0]   nlo_im;
    logic [QBITS-1:0]   q_re;
    logic [QBITS-1:0]   q_im;
  } cau_dp_t;

endpackage

// File: rtl/cau_front.sv
module cau_front
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  input  cau_in_t in_data,
  output cau_dp_t dp_out
);

  localparam int OP_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam int SH   = 32 - OP_W;

  logic signed [31:0] ar_ext, ai_ext, br_ext, bi_ext;

  logic               s1_valid_r;
  logic [1:0]         s1_op_r;
  logic signed [31:0] s1_ar_r, s1_ai_r, s1_br_r, s1_bi_r;

  logic               s2_valid_r;
  logic [1:0]         s2_op_r;
  logic signed [63:0] s2_p_rr_r, s2_p_ii_r, s2_p_ri_r, s2_p_ir_r, s2_sq_r_r, s2_sq_i_r;
  logic signed [65:0] s2_val_re_r, s2_val_im_r;

  logic               s3_valid_r;
  logic [1:0]         s3_op_r;
  logic signed [65:0] s3_val_re_r, s3_val_im_r;
  logic [63:0]        s3_den_r;

  logic signed [64:0] m_re, m_im, d_re, d_im;
  logic [63:0]        den_sum;

  logic               neg_re, neg_im;
  logic signed [65:0] abs_re, abs_im;
  logic [95:0]        n_re, n_im;

  cau_dp_t            dp_r;

  always_comb begin
    ar_ext = $signed(in_data.a_re << SH) >>> SH;
    ai_ext = $signed(in_data.a_im << SH) >>> SH;
    br_ext = $signed(in_data.b_re << SH) >>> SH;
    bi_ext = $signed(in_data.b_im << SH) >>> SH;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_valid;
    end
    s1_op_r <= in_data.req_type;
    s1_ar_r <= ar_ext;
    s1_ai_r <= ai_ext;
    s1_br_r <= br_ext;
    s1_bi_r <= bi_ext;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
    s2_op_r   <= s1_op_r;
    s2_p_rr_r <= s1_ar_r * s1_br_r;
    s2_p_ii_r <= s1_ai_r * s1_bi_r;
    s2_p_ri_r <= s1_ar_r * s1_bi_r;
    s2_p_ir_r <= s1_ai_r * s1_br_r;
    s2_sq_r_r <= s1_br_r * s1_br_r;
    s2_sq_i_r <= s1_bi_r * s1_bi_r;
    if (s1_op_r == OP_SUB) begin
      s2_val_re_r <= 66'(s1_ar_r) - 66'(s1_br_r);
      s2_val_im_r <= 66'(s1_ai_r) - 66'(s1_bi_r);
    end else begin
      s2_val_re_r <= 66'(s1_ar_r) + 66'(s1_br_r);
      s2_val_im_r <= 66'(s1_ai_r) + 66'(s1_bi_r);
    end
  end

  always_comb begin
    m_re    = 65'(s2_p_rr_r) - 65'(s2_p_ii_r);
    m_im    = 65'(s2_p_ri_r) + 65'(s2_p_ir_r);
    d_re    = 65'(s2_p_rr_r) + 65'(s2_p_ii_r);
    d_im    = 65'(s2_p_ir_r) - 65'(s2_p_ri_r);
    den_sum = $unsigned(s2_sq_r_r) + $unsigned(s2_sq_i_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
    s3_op_r  <= s2_op_r;
    s3_den_r <= den_sum;
    unique case (s2_op_r)
      OP_MUL: begin
        s3_val_re_r <= 66'(m_re >>> FRAC_BITS);
        s3_val_im_r <= 66'(m_im >>> FRAC_BITS);
      end
      OP_DIV: begin
        s3_val_re_r <= 66'(d_re);
        s3_val_im_r <= 66'(d_im);
      end
      default: begin
        s3_val_re_r <= s2_val_re_r;
        s3_val_im_r <= s2_val_im_r;
      end
    endcase
  end

  always_comb begin
    neg_re = s3_val_re_r[65];
    neg_im = s3_val_im_r[65];
    abs_re = neg_re ? -s3_val_re_r : s3_val_re_r;
    abs_im = neg_im ? -s3_val_im_r : s3_val_im_r;
    n_re   = {32'b0, abs_re[63:0]} << FRAC_BITS;
    n_im   = {32'b0, abs_im[63:0]} << FRAC_BITS;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r.valid <= 1'b0;
    end else begin
      dp_r.valid <= s3_valid_r;
    end
    dp_r.op     <= s3_op_r;
    dp_r.dz     <= (s3_op_r == OP_DIV) && (s3_den_r == 64'd0);
    dp_r.neg_re <= neg_re;
    dp_r.neg_im <= neg_im;
    dp_r.ovf_re <= n_re[95:32] >= s3_den_r;
    dp_r.ovf_im <= n_im[95:32] >= s3_den_r;
    dp_r.val_re <= s3_val_re_r;
    dp_r.val_im <= s3_val_im_r;
    dp_r.den    <= s3_den_r;
    dp_r.rem_re <= n_re[95:32];
    dp_r.rem_im <= n_im[95:32];
    dp_r.nlo_re <= n_re[31:0];
    dp_r.nlo_im <= n_im[31:0];
    dp_r.q_re   <= '0;
    dp_r.q_im   <= '0;
  end

  assign dp_out = dp_r;

endmodule

// File: rtl/cau_div_stage.sv
module cau_div_stage
  import cau_pkg::*;
#(
  parameter int BIT_IDX = 0
) (
  input  logic    clk,
  input  logic    rst_n,
  input  cau_dp_t dp_in,
  output cau_dp_t dp_out
);

  logic [64:0] t_re, t_im;
  logic        ge_re, ge_im;
  logic [64:0] d_re, d_im;
  cau_dp_t     dp_nxt;
  cau_dp_t     dp_r;

  always_comb begin
    t_re  = {dp_in.rem_re, dp_in.nlo_re[BIT_IDX]};
    t_im  = {dp_in.rem_im, dp_in.nlo_im[BIT_IDX]};
    ge_re = t_re >= {1'b0, dp_in.den};
    ge_im = t_im >= {1'b0, dp_in.den};
    d_re  = t_re - {1'b0, dp_in.den};
    d_im  = t_im - {1'b0, dp_in.den};

    dp_nxt = dp_in;
    dp_nxt.rem_re = ge_re ? d_re[63:0] : t_re[63:0];
    dp_nxt.rem_im = ge_im ? d_im[63:0] : t_im[63:0];
    dp_nxt.q_re[BIT_IDX] = ge_re;
    dp_nxt.q_im[BIT_IDX] = ge_im;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dp_r <= '0;
    end else begin
      dp_r <= dp_nxt;
    end
  end

  assign dp_out = dp_r;

endmodule

// File: rtl/cau_back.sv
module cau_back
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  cau_dp_t  dp_in,
  output logic     out_valid,
  output cau_out_t out_data
);

  localparam int OP_W = (DATA_WIDTH > 32) ? 32 : DATA_WIDTH;
  localparam logic signed [65:0] MAXV = (66'sd1 <<< (OP_W - 1)) - 66'sd1;
  localparam logic signed [65:0] MINV = -MAXV - 66'sd1;

  // Returns the clamp flag above the 32-bit saturated value.
  function automatic logic [32:0] sat(input logic signed [65:0] v, input logic ovf,
                                      input logic neg);
    logic [32:0] r;
    if (ovf) begin
      r = neg ? {1'b1, MINV[31:0]} : {1'b1, MAXV[31:0]};
    end else if (v > MAXV) begin
      r = {1'b1, MAXV[31:0]};
    end else if (v < MINV) begin
      r = {1'b1, MINV[31:0]};
    end else begin
      r = {1'b0, v[31:0]};
    end
    return r;
  endfunction

  logic signed [65:0] qv_re, qv_im;
  logic [32:0]        s_re, s_im;
  logic               out_valid_r;
  cau_out_t           out_r;
  cau_out_t           out_nxt;

  always_comb begin
    qv_re = $signed({34'b0, dp_in.q_re});
    qv_im = $signed({34'b0, dp_in.q_im});
    if (dp_in.neg_re) begin
      qv_re = -qv_re;
    end
    if (dp_in.neg_im) begin
      qv_im = -qv_im;
    end
    if (dp_in.op == OP_DIV) begin
      s_re = sat(qv_re, dp_in.ovf_re, dp_in.neg_re);
      s_im = sat(qv_im, dp_in.ovf_im, dp_in.neg_im);
    end else begin
      s_re = sat(dp_in.val_re, 1'b0, 1'b0);
      s_im = sat(dp_in.val_im, 1'b0, 1'b0);
    end
    if (dp_in.dz) begin
      out_nxt.result_re      = '0;
      out_nxt.result_im      = '0;
      out_nxt.saturated      = 1'b0;
      out_nxt.divide_by_zero = 1'b1;
    end else begin
      out_nxt.result_re      = s_re[31:0];
      out_nxt.result_im      = s_im[31:0];
      out_nxt.saturated      = s_re[32] | s_im[32];
      out_nxt.divide_by_zero = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dp_in.valid;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: rtl/complex_arithmetic_unit.sv
// Every operation takes the same path: the front-end registers (s1, s2, s3, dp_r), the divider
// stages, then the output register in cau_back, which drives out_valid and out_data.
// Throughput: one item per cycle; busy is always low, and the receiver cannot stall.
// The depth is set by the 32-stage restoring divider, which every item passes through.
// Reset (rst_n low, synchronous) clears all valid bits; items in flight are dropped.
module complex_arithmetic_unit
  import cau_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  cau_in_t  in_data,
  output logic     out_valid,
  output cau_out_t out_data
);

  cau_dp_t chain [QBITS+1];

  assign busy = 1'b0;

  cau_front #(
    .DATA_WIDTH(DATA_WIDTH),
    .FRAC_BITS (FRAC_BITS)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(start),
    .in_data (in_data),
    .dp_out  (chain[0])
  );

  for (genvar j = 0; j < QBITS; j++) begin : g_div
    cau_div_stage #(
      .BIT_IDX(QBITS - 1 - j)
    ) u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .dp_in (chain[j]),
      .dp_out(chain[j+1])
    );
  end

  cau_back #(
    .DATA_WIDTH(DATA_WIDTH)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .dp_in    (chain[QBITS]),
    .out_valid(out_valid),
    .out_data (out_data)
  );

endmodule
